// ===== hw/rtl/pdr_pkg.sv =====
// ----------------------------------------------------------------------------
// pdr_pkg: shared types, constants and microcode for the difficulty retarget
// Holds the default widths, register indexes, datapath op codes, jump
// conditions and the control store read by the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package pdr_pkg;

  // Defaults for the top-level parameters
  localparam int PDR_MANTISSA_BITS = 24;
  localparam int PDR_MAX_ORDER     = 231;

  // Fixed field widths
  localparam int WORD_W    = 32;
  localparam int TIME_W    = 64;
  localparam int IN_W      = WORD_W + 2 * TIME_W;
  localparam int MOC_W     = 8;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DESIRED_BLOCK_SECONDS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REVIEW_CYCLE_BLOCKS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ORDER_CHANGE      = 2'd2;

  // Datapath operations, one per control word
  typedef enum logic [3:0] {
    OP_LOAD,
    OP_TARGET,
    OP_INIT,
    OP_STEP,
    OP_MUL,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_NORM,
    OP_PACK,
    OP_EMIT
  } pdr_op_t;

  // Jump conditions
  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_INPUT,
    C_BOTH_ZERO,
    C_LOOP_MORE,
    C_SKIP_DIV,
    C_DIV_MORE,
    C_OUT_BUSY
  } pdr_cond_t;

  // Step counter and program addresses
  localparam int UPC_W = 4;
  typedef logic [UPC_W-1:0] upc_t;

  localparam upc_t UA_WAIT     = 4'd0;
  localparam upc_t UA_TARGET   = 4'd1;
  localparam upc_t UA_INIT     = 4'd2;
  localparam upc_t UA_LOOP     = 4'd3;
  localparam upc_t UA_MUL      = 4'd4;
  localparam upc_t UA_DIV_INIT = 4'd5;
  localparam upc_t UA_DIV_STEP = 4'd6;
  localparam upc_t UA_NORM     = 4'd7;
  localparam upc_t UA_PACK     = 4'd8;
  localparam upc_t UA_EMIT     = 4'd9;
  localparam upc_t UA_LAST     = UA_EMIT;

  typedef struct packed {
    pdr_op_t   op;
    pdr_cond_t cond;
    upc_t      jump;
  } uword_t;

  // Datapath flags seen by the sequencer
  typedef struct packed {
    logic both_zero;
    logic loop_more;
    logic skip_div;
    logic div_more;
  } pdr_status_t;

  // Control store: jump to .jump when .cond holds, else fall through
  function automatic uword_t pdr_ucode(upc_t pc);
    uword_t w;
    case (pc)
      UA_WAIT:     w = '{op: OP_LOAD,     cond: C_NO_INPUT,  jump: UA_WAIT};
      UA_TARGET:   w = '{op: OP_TARGET,   cond: C_NEVER,     jump: UA_WAIT};
      UA_INIT:     w = '{op: OP_INIT,     cond: C_BOTH_ZERO, jump: UA_EMIT};
      UA_LOOP:     w = '{op: OP_STEP,     cond: C_LOOP_MORE, jump: UA_LOOP};
      UA_MUL:      w = '{op: OP_MUL,      cond: C_SKIP_DIV,  jump: UA_PACK};
      UA_DIV_INIT: w = '{op: OP_DIV_INIT, cond: C_NEVER,     jump: UA_WAIT};
      UA_DIV_STEP: w = '{op: OP_DIV_STEP, cond: C_DIV_MORE,  jump: UA_DIV_STEP};
      UA_NORM:     w = '{op: OP_NORM,     cond: C_NEVER,     jump: UA_WAIT};
      UA_PACK:     w = '{op: OP_PACK,     cond: C_NEVER,     jump: UA_WAIT};
      UA_EMIT:     w = '{op: OP_EMIT,     cond: C_OUT_BUSY,  jump: UA_EMIT};
      default:     w = '{op: OP_LOAD,     cond: C_ALWAYS,    jump: UA_WAIT};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/packed_difficulty_retarget.sv =====
// ----------------------------------------------------------------------------
// packed_difficulty_retarget: microcoded difficulty retarget unit
// Takes a packed difficulty word and a review cycle's timestamps and
// returns the adjusted packed word.
// ----------------------------------------------------------------------------
// One word is processed at a time. The order loop runs one step a cycle and
// takes at most max_order_change order steps; the mantissa scaling then uses
// a restoring divider that yields one quotient bit a cycle. When the order
// budget runs out, the order leaves its range or the scaled elapsed time is
// zero the divider is skipped, and when both elapsed time and target are zero
// the word is returned unchanged without the order loop. A finished result
// waits in the output register while the next word is accepted.
// Configuration writes take effect at once and are meant for idle periods.
`default_nettype none

module packed_difficulty_retarget import pdr_pkg::*; #(
  parameter int MANTISSA_BITS = PDR_MANTISSA_BITS,
  parameter int MAX_ORDER     = PDR_MAX_ORDER
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // input stream
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // current_difficulty[31:0], cycle_begin_s[95:32], cycle_end_s[159:96]
  input  wire logic [IN_W-1:0]       s_axis_tdata,
  // output stream
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // new_difficulty[31:0]
  output logic [WORD_W-1:0]          m_axis_tdata,
  // configuration writes
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [WORD_W-1:0]     cfg_data
);

  // Configuration registers
  logic [WORD_W-1:0] desired_block_seconds;
  logic [WORD_W-1:0] review_cycle_blocks;
  logic [MOC_W-1:0]  max_order_change;

  always_ff @(posedge clk) begin
    if (rst) begin
      desired_block_seconds <= WORD_W'(60);
      review_cycle_blocks   <= WORD_W'(1440);
      max_order_change      <= MOC_W'(3);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DESIRED_BLOCK_SECONDS: desired_block_seconds <= cfg_data;
        REG_REVIEW_CYCLE_BLOCKS:   review_cycle_blocks   <= cfg_data;
        REG_MAX_ORDER_CHANGE:      max_order_change      <= cfg_data[MOC_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer
  upc_t        upc, upc_next;
  uword_t      uw;
  pdr_status_t status;
  logic [WORD_W-1:0] result;
  logic        out_busy;
  logic        take;

  assign uw       = pdr_ucode(upc);
  assign out_busy = m_axis_tvalid && !m_axis_tready;

  always_comb begin
    case (uw.cond)
      C_NEVER:     take = 1'b0;
      C_ALWAYS:    take = 1'b1;
      C_NO_INPUT:  take = !s_axis_tvalid;
      C_BOTH_ZERO: take = status.both_zero;
      C_LOOP_MORE: take = status.loop_more;
      C_SKIP_DIV:  take = status.skip_div;
      C_DIV_MORE:  take = status.div_more;
      C_OUT_BUSY:  take = out_busy;
      default:     take = 1'b1;
    endcase
  end

  always_comb begin
    if (take) begin
      upc_next = uw.jump;
    end else if (upc == UA_LAST) begin
      upc_next = UA_WAIT;
    end else begin
      upc_next = upc + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= UA_WAIT;
    end else begin
      upc <= upc_next;
    end
  end

  // No word is taken while reset is held
  assign s_axis_tready = !rst && (uw.op == OP_LOAD);

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (uw.op == OP_EMIT && !out_busy) begin
      m_axis_tvalid <= 1'b1;
      m_axis_tdata  <= result;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  pdr_datapath #(
    .MANTISSA_BITS (MANTISSA_BITS),
    .MAX_ORDER     (MAX_ORDER)
  ) u_dp (
    .clk                   (clk),
    .rst                   (rst),
    .op                    (uw.op),
    .in_data               (s_axis_tdata),
    .desired_block_seconds (desired_block_seconds),
    .review_cycle_blocks   (review_cycle_blocks),
    .max_order_change      (max_order_change),
    .status                (status),
    .result                (result)
  );

  // Step counter stays inside the program
  a_upc_range: assert property (@(posedge clk) disable iff (rst)
    upc <= UA_LAST)
    else $error("step counter outside program");

  // An accepted word starts the program
  a_accept_start: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> (upc == UA_TARGET))
    else $error("accept did not start program");

  // A free output slot takes the result and the sequencer returns to wait
  a_emit: assert property (@(posedge clk) disable iff (rst)
    (upc == UA_EMIT && !out_busy) |=> (m_axis_tvalid && upc == UA_WAIT))
    else $error("result not delivered");

endmodule

`default_nettype wire

// ===== hw/rtl/pdr_datapath.sv =====
// ----------------------------------------------------------------------------
// pdr_datapath: registers and arithmetic for the difficulty retarget
// Decodes the packed word, steps the order, scales the mantissa with a
// restoring divider (one quotient bit a cycle) and repacks the result.
// ----------------------------------------------------------------------------
`default_nettype none

module pdr_datapath import pdr_pkg::*; #(
  parameter int MANTISSA_BITS = PDR_MANTISSA_BITS,
  parameter int MAX_ORDER     = PDR_MAX_ORDER
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire pdr_op_t            op,
  input  wire logic [IN_W-1:0]    in_data,
  input  wire logic [WORD_W-1:0]  desired_block_seconds,
  input  wire logic [WORD_W-1:0]  review_cycle_blocks,
  input  wire logic [MOC_W-1:0]   max_order_change,
  output pdr_status_t             status,
  output logic [WORD_W-1:0]       result
);

  localparam int ORD_W = WORD_W + 2 - MANTISSA_BITS;  // signed order with headroom
  localparam int OF_W  = WORD_W - MANTISSA_BITS;      // order field in the word
  localparam int MAN_W = MANTISSA_BITS + 1;           // mantissa with lead bit
  localparam int QW    = MANTISSA_BITS + 2;           // quotient bits
  localparam int PW    = WORD_W + MAN_W;              // product width
  localparam int CNT_W = $clog2(QW + 1);

  localparam logic signed [ORD_W-1:0] ORD_ONE = ORD_W'(1);
  localparam logic signed [ORD_W-1:0] MAX_ORD = ORD_W'(MAX_ORDER);
  localparam logic [63:0] INF_WIDE = (64'(MAX_ORDER) + 64'd1) << MANTISSA_BITS;
  localparam logic [WORD_W-1:0] INF_CODE = INF_WIDE[WORD_W-1:0];

  // Working registers
  logic [WORD_W-1:0]       word_r;
  logic [WORD_W-1:0]       elapsed;
  logic [WORD_W-1:0]       target;
  logic signed [ORD_W-1:0] ord;
  logic [MAN_W-1:0]        man;
  logic [WORD_W-1:0]       span;
  logic [MOC_W-1:0]        step_cnt;
  logic                    rise;
  logic                    keep;
  logic [PW-1:0]           prod;
  logic [WORD_W-1:0]       rem;
  logic [QW-1:0]           quo;
  logic [CNT_W-1:0]        div_cnt;

  // Elapsed time from the input word: clamp at zero, saturate to 32 bits
  logic [TIME_W-1:0] t0, t1, tdiff;
  logic [WORD_W-1:0] elapsed_in;

  assign t0    = in_data[WORD_W +: TIME_W];
  assign t1    = in_data[WORD_W + TIME_W +: TIME_W];
  assign tdiff = t1 - t0;

  always_comb begin
    if (t1 <= t0) begin
      elapsed_in = '0;
    end else if (tdiff[TIME_W-1:WORD_W] != '0) begin
      elapsed_in = '1;
    end else begin
      elapsed_in = tdiff[WORD_W-1:0];
    end
  end

  // Target time, wrapped to 32 bits
  logic [WORD_W-1:0] target_mul;
  assign target_mul = desired_block_seconds * review_cycle_blocks;

  // One order step
  logic signed [ORD_W-1:0] ord_up, ord_dn, ord_loop;
  logic [WORD_W:0]         span_dbl;
  logic [WORD_W-1:0]       span_loop;
  logic                    over, under, budget_out, keep_set, loop_more;

  assign ord_up     = ord + ORD_ONE;
  assign ord_dn     = ord - ORD_ONE;
  assign span_dbl   = {span, 1'b0};
  assign over       = span_dbl > {1'b0, target};
  assign under      = (span >> 1) < target;
  assign budget_out = (step_cnt == max_order_change);

  always_comb begin
    loop_more = 1'b0;
    keep_set  = 1'b0;
    ord_loop  = ord;
    span_loop = span;
    if (budget_out) begin
      keep_set = 1'b1;
    end else if (rise) begin
      if (!over) begin
        ord_loop = ord_up;
        if (ord_up > MAX_ORD) begin
          keep_set = 1'b1;
        end else begin
          span_loop = span_dbl[WORD_W-1:0];
          loop_more = 1'b1;
        end
      end
    end else begin
      if (!under) begin
        if (ord == '0) begin
          ord_loop = '1;
          keep_set = 1'b1;
        end else begin
          ord_loop  = ord_dn;
          span_loop = span >> 1;
          loop_more = 1'b1;
        end
      end
    end
  end

  // Scaled mantissa product
  logic [PW-1:0] prod_mul;
  assign prod_mul = target * man;

  // Restoring divide step
  logic [WORD_W:0]   trial, trial_sub;
  logic              q_bit;
  logic [WORD_W-1:0] rem_next;

  assign trial     = {rem, quo[QW-1]};
  assign trial_sub = trial - {1'b0, span};
  assign q_bit     = trial >= {1'b0, span};
  assign rem_next  = q_bit ? trial_sub[WORD_W-1:0] : trial[WORD_W-1:0];

  // Register updates per control word
  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        word_r  <= in_data[WORD_W-1:0];
        elapsed <= elapsed_in;
      end
      OP_TARGET: begin
        target <= target_mul;
      end
      OP_INIT: begin
        ord      <= $signed(ORD_W'(word_r[WORD_W-1:MANTISSA_BITS]));
        man      <= {1'b1, word_r[MANTISSA_BITS-1:0]};
        span     <= elapsed;
        rise     <= elapsed < target;
        step_cnt <= '0;
        keep     <= 1'b0;
        result   <= word_r;
      end
      OP_STEP: begin
        ord  <= ord_loop;
        span <= span_loop;
        if (keep_set) begin
          keep <= 1'b1;
        end
        if (loop_more) begin
          step_cnt <= step_cnt + 1'b1;
        end
      end
      OP_MUL: begin
        prod <= prod_mul;
      end
      OP_DIV_INIT: begin
        rem     <= WORD_W'(prod[PW-1:QW]);
        quo     <= prod[QW-1:0];
        div_cnt <= CNT_W'(QW);
      end
      OP_DIV_STEP: begin
        rem     <= rem_next;
        quo     <= {quo[QW-2:0], q_bit};
        div_cnt <= div_cnt - 1'b1;
      end
      OP_NORM: begin
        if (rise && quo[QW-1]) begin
          ord <= ord_up;
          man <= quo[QW-1:1];
        end else if (!rise && quo[QW-1:QW-2] == 2'b00) begin
          ord <= ord_dn;
          man <= {quo[MANTISSA_BITS-1:0], 1'b0};
        end else begin
          man <= quo[MAN_W-1:0];
        end
      end
      OP_PACK: begin
        if (ord[ORD_W-1]) begin
          result <= '0;
        end else if (ord > MAX_ORD) begin
          result <= INF_CODE;
        end else begin
          result <= {ord[OF_W-1:0], man[MANTISSA_BITS-1:0]};
        end
      end
      default: begin
      end
    endcase
  end

  // Flags for the sequencer
  assign status.both_zero = (elapsed == '0) && (target == '0);
  assign status.loop_more = loop_more;
  assign status.skip_div  = keep || (span == '0);
  assign status.div_more  = (div_cnt != CNT_W'(1));

  // Partial remainder stays below the divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (op == OP_DIV_STEP) |-> (rem < span))
    else $error("divider remainder not below divisor");

  // Raising quotient is at least one in mantissa scale
  a_rise_quo: assert property (@(posedge clk) disable iff (rst)
    (op == OP_NORM && rise) |-> (quo[QW-1:QW-2] != 2'b00))
    else $error("rising quotient below one");

  // Lowering quotient stays below two in mantissa scale
  a_fall_quo: assert property (@(posedge clk) disable iff (rst)
    (op == OP_NORM && !rise) |-> !quo[QW-1])
    else $error("lowering quotient too large");

endmodule

`default_nettype wire
